// ===== rtl/core/rms_pkg.sv =====
// Shared widths, command codes and register indexes of the rotary menu selector.
package rms_pkg;

  // Width of the key debounce counter.
  localparam int unsigned TimerBits = 11;

  // Field widths.
  localparam int unsigned CmdW      = 2;
  localparam int unsigned ItemW     = 4;
  localparam int unsigned DebounceW = 11;

  // Width in which the debounce counter and its threshold are compared.
  localparam int unsigned CmpW = (TimerBits > DebounceW) ? TimerBits : DebounceW;

  // Configuration port.
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 11;

  localparam logic [CfgIdxW-1:0] CfgDebounceTicks = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgLastItem      = 2'd1;

  // Register values after reset.
  localparam logic [DebounceW-1:0] DebounceReset = 11'd100;
  localparam logic [ItemW-1:0]     LastItemReset = 4'd3;

  // Input commands.
  localparam logic [CmdW-1:0] CmdEnc  = 2'd0;
  localparam logic [CmdW-1:0] CmdKey  = 2'd1;
  localparam logic [CmdW-1:0] CmdTick = 2'd2;

  // Largest debounce counter value.
  localparam logic [TimerBits-1:0] TimerMax = {TimerBits{1'b1}};

  // One input beat.
  typedef struct packed {
    logic [CmdW-1:0] cmd;
    logic            a_level;
    logic            b_level;
    logic            key_level;
  } evt_t;

  // One result beat.
  typedef struct packed {
    logic             mode;
    logic [ItemW-1:0] selection;
    logic [ItemW-1:0] running_function;
    logic             entered;
    logic             returned;
    logic             redraw_menu;
  } res_t;

endpackage

// ===== rtl/core/rms_intf.sv =====
// Channel interfaces of the rotary menu selector: events, results and configuration.
interface rms_evt_if;
  import rms_pkg::*;

  logic            valid;
  logic            ready;
  logic [CmdW-1:0] cmd;
  logic            a_level;
  logic            b_level;
  logic            key_level;

  modport source (output valid, cmd, a_level, b_level, key_level, input ready);
  modport sink (input valid, cmd, a_level, b_level, key_level, output ready);
endinterface

interface rms_res_if;
  import rms_pkg::*;

  logic             valid;
  logic             ready;
  logic             mode;
  logic [ItemW-1:0] selection;
  logic [ItemW-1:0] running_function;
  logic             entered;
  logic             returned;
  logic             redraw_menu;

  modport source (
    output valid, mode, selection, running_function, entered, returned, redraw_menu,
    input ready
  );
  modport sink (
    input valid, mode, selection, running_function, entered, returned, redraw_menu,
    output ready
  );
endinterface

interface rms_cfg_if;
  import rms_pkg::*;

  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/rotary_menu_selector.sv =====
// Top level of the rotary menu selector: event decode, menu state and debounced key.
//
//   channel   | direction | handshake      | payload
//   ----------+-----------+----------------+---------------------------------------------
//   evt_i     | in        | valid / ready  | cmd, a_level, b_level, key_level
//   res_o     | out       | valid / ready  | mode, selection, running_function, pulses
//   cfg_i     | in        | valid / ready  | index, data (debounce_ticks, last_item)
//
// Each event beat is registered in the input register, then evaluated against the state,
// which updates the state and loads the result register. One beat per cycle is taken while
// the result side does not stall and so hold the evaluation stage.
// Reset returns the block to menu mode with selection zero and no pending steps;
// the registers take debounce_ticks 100 and last_item 3. No clearing pass is needed.
// A stalled result holds the evaluation stage; the input register then fills and
// evt_i.ready drops. cfg_i is always ready.
module rotary_menu_selector (
  input  logic clk_i,
  input  logic rst_ni,
  rms_evt_if.sink   evt_i,
  rms_res_if.source res_o,
  rms_cfg_if.sink   cfg_i
);
  import rms_pkg::*;

  // Configuration registers.
  logic [DebounceW-1:0] debounce_q;
  logic [ItemW-1:0]     last_item_q;

  // Input stage.
  logic evt_vld_q;
  evt_t evt_q;

  // Result stage.
  logic res_vld_q;
  res_t res_q, res_d;

  // Block state.
  logic                 run_mode_q, run_mode_d;
  logic [ItemW-1:0]     menu_idx_q, menu_idx_d;
  logic [ItemW-1:0]     latched_q, latched_d;
  logic                 ccw_start_q, ccw_start_d;
  logic                 ccw_conf_q, ccw_conf_d;
  logic                 cw_start_q, cw_start_d;
  logic                 cw_conf_q, cw_conf_d;
  logic                 armed_q, armed_d;
  logic [TimerBits-1:0] elapsed_q, elapsed_d;

  // Scratch values of the tick evaluation.
  logic [ItemW-1:0]     idx_ccw;
  logic [TimerBits-1:0] elapsed_inc;
  logic                 accept;
  logic                 redraw;

  logic advance;

  // Evaluation fires when the input stage holds a beat and the result slot frees up.
  assign advance     = evt_vld_q && (!res_vld_q || res_o.ready);
  assign evt_i.ready = !evt_vld_q || advance;
  assign cfg_i.ready = 1'b1;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q  <= DebounceReset;
      last_item_q <= LastItemReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CfgDebounceTicks: debounce_q  <= cfg_i.data[DebounceW-1:0];
        CfgLastItem:      last_item_q <= cfg_i.data[ItemW-1:0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      evt_vld_q <= 1'b0;
    end else if (evt_i.ready) begin
      evt_vld_q <= evt_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (evt_i.valid && evt_i.ready) begin
      evt_q.cmd       <= evt_i.cmd;
      evt_q.a_level   <= evt_i.a_level;
      evt_q.b_level   <= evt_i.b_level;
      evt_q.key_level <= evt_i.key_level;
    end
  end

  // Next state and result for the registered event.
  always_comb begin
    run_mode_d  = run_mode_q;
    menu_idx_d  = menu_idx_q;
    latched_d   = latched_q;
    ccw_start_d = ccw_start_q;
    ccw_conf_d  = ccw_conf_q;
    cw_start_d  = cw_start_q;
    cw_conf_d   = cw_conf_q;
    armed_d     = armed_q;
    elapsed_d   = elapsed_q;
    idx_ccw     = menu_idx_q;
    elapsed_inc = elapsed_q;
    accept      = 1'b0;
    redraw      = 1'b0;
    res_d       = '0;

    unique case (evt_q.cmd)
      CmdEnc: begin
        // Equal levels turn counter-clockwise; a repeat in one direction confirms a step.
        if (evt_q.a_level == evt_q.b_level) begin
          if (ccw_start_q) begin
            ccw_conf_d = 1'b1;
          end else begin
            ccw_start_d = 1'b1;
          end
          cw_start_d = 1'b0;
        end else begin
          if (cw_start_q) begin
            cw_conf_d = 1'b1;
          end else begin
            cw_start_d = 1'b1;
          end
          ccw_start_d = 1'b0;
        end
      end
      CmdKey: begin
        // A press restarts the debounce count.
        if (!evt_q.key_level) begin
          armed_d   = 1'b1;
          elapsed_d = '0;
        end
      end
      CmdTick: begin
        // Pending steps apply in menu mode, counter-clockwise first.
        if (!run_mode_q) begin
          if (ccw_conf_q) begin
            ccw_conf_d = 1'b0;
            idx_ccw    = (menu_idx_q >= last_item_q) ? '0 : menu_idx_q + 1'b1;
            redraw     = 1'b1;
          end
          menu_idx_d = idx_ccw;
          if (cw_conf_q) begin
            cw_conf_d  = 1'b0;
            menu_idx_d = (idx_ccw == '0) ? last_item_q : idx_ccw - 1'b1;
            redraw     = 1'b1;
          end
        end

        // Debounce count saturates; the press is taken once it exceeds the threshold.
        if (armed_q) begin
          elapsed_inc = (elapsed_q != TimerMax) ? elapsed_q + 1'b1 : elapsed_q;
          elapsed_d   = elapsed_inc;
          if (CmpW'(elapsed_inc) > CmpW'(debounce_q)) begin
            accept    = 1'b1;
            armed_d   = 1'b0;
            elapsed_d = '0;
          end
        end

        // An accepted press toggles the mode.
        if (accept) begin
          if (!run_mode_q) begin
            latched_d     = menu_idx_d;
            run_mode_d    = 1'b1;
            ccw_start_d   = 1'b0;
            ccw_conf_d    = 1'b0;
            cw_start_d    = 1'b0;
            cw_conf_d     = 1'b0;
            res_d.entered = 1'b1;
          end else begin
            run_mode_d     = 1'b0;
            res_d.returned = 1'b1;
            redraw         = 1'b1;
          end
        end
      end
      default: ;
    endcase

    res_d.mode             = run_mode_d;
    res_d.selection        = menu_idx_d;
    res_d.running_function = latched_d;
    res_d.redraw_menu      = redraw;
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_mode_q  <= 1'b0;
      menu_idx_q  <= '0;
      latched_q   <= '0;
      ccw_start_q <= 1'b0;
      ccw_conf_q  <= 1'b0;
      cw_start_q  <= 1'b0;
      cw_conf_q   <= 1'b0;
      armed_q     <= 1'b0;
      elapsed_q   <= '0;
    end else if (advance) begin
      run_mode_q  <= run_mode_d;
      menu_idx_q  <= menu_idx_d;
      latched_q   <= latched_d;
      ccw_start_q <= ccw_start_d;
      ccw_conf_q  <= ccw_conf_d;
      cw_start_q  <= cw_start_d;
      cw_conf_q   <= cw_conf_d;
      armed_q     <= armed_d;
      elapsed_q   <= elapsed_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (advance) begin
      res_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      res_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid            = res_vld_q;
  assign res_o.mode             = res_q.mode;
  assign res_o.selection        = res_q.selection;
  assign res_o.running_function = res_q.running_function;
  assign res_o.entered          = res_q.entered;
  assign res_o.returned         = res_q.returned;
  assign res_o.redraw_menu      = res_q.redraw_menu;

endmodule

// ===== tb/rotary_menu_selector_tb.sv =====
`timescale 1ns / 100ps
// Testbench of the rotary menu selector: directed and random events checked against a state predictor.
module rotary_menu_selector_tb;
  import rms_pkg::*;

  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned LongHold   = 60;
  localparam int unsigned PhaseItems = 40;

  // Command code that the block must ignore.
  localparam logic [CmdW-1:0] CmdUnused = 2'd3;

  // Register indexes that hold no register.
  localparam logic [CfgIdxW-1:0] CfgSpareLo = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareHi = 2'd3;

  // One register write of a configuration sequence.
  typedef struct {
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] data;
  } reg_write_t;

  // Tracks the menu, step marks and key debounce, and holds the reports still to come.
  class menu_state_tracker;
    logic [DebounceW-1:0] debounce_ticks;
    logic [ItemW-1:0]     last_item;
    bit                   run_mode;
    logic [ItemW-1:0]     menu_index;
    logic [ItemW-1:0]     latched_function;
    bit                   ccw_started;
    bit                   ccw_confirmed;
    bit                   cw_started;
    bit                   cw_confirmed;
    bit                   key_armed;
    logic [TimerBits-1:0] press_elapsed;
    res_t                 pending_reports[$];
    int unsigned          errors;

    function new();
      debounce_ticks   = DebounceReset;
      last_item        = LastItemReset;
      run_mode         = 1'b0;
      menu_index       = '0;
      latched_function = '0;
      clear_marks();
      key_armed        = 1'b0;
      press_elapsed    = '0;
      errors           = 0;
    endfunction

    function void clear_marks();
      ccw_started   = 1'b0;
      ccw_confirmed = 1'b0;
      cw_started    = 1'b0;
      cw_confirmed  = 1'b0;
    endfunction

    // Register writes are masked to the register widths; other indexes do nothing.
    function void set_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CfgDebounceTicks: debounce_ticks = data[DebounceW-1:0];
        CfgLastItem:      last_item = data[ItemW-1:0];
        default: ;
      endcase
    endfunction

    // Applies one accepted event beat and queues the report it must produce.
    function void note_event(evt_t ev);
      res_t rep;
      bit   accept;
      rep    = '0;
      accept = 1'b0;
      case (ev.cmd)
        CmdEnc: begin
          if (ev.a_level == ev.b_level) begin
            if (ccw_started) ccw_confirmed = 1'b1;
            else ccw_started = 1'b1;
            cw_started = 1'b0;
          end else begin
            if (cw_started) cw_confirmed = 1'b1;
            else cw_started = 1'b1;
            ccw_started = 1'b0;
          end
        end
        CmdKey: begin
          if (!ev.key_level) begin
            key_armed     = 1'b1;
            press_elapsed = '0;
          end
        end
        CmdTick: begin
          // Pending steps move the selection only in menu mode.
          if (!run_mode) begin
            if (ccw_confirmed) begin
              ccw_confirmed   = 1'b0;
              menu_index      = (menu_index >= last_item) ? '0 : menu_index + 1'b1;
              rep.redraw_menu = 1'b1;
            end
            if (cw_confirmed) begin
              cw_confirmed    = 1'b0;
              menu_index      = (menu_index == '0) ? last_item : menu_index - 1'b1;
              rep.redraw_menu = 1'b1;
            end
          end
          // The debounce count saturates and the press is taken once it passes the threshold.
          if (key_armed) begin
            if (press_elapsed != TimerMax) press_elapsed = press_elapsed + 1'b1;
            if (press_elapsed > debounce_ticks) begin
              accept        = 1'b1;
              key_armed     = 1'b0;
              press_elapsed = '0;
            end
          end
          if (accept) begin
            if (!run_mode) begin
              latched_function = menu_index;
              run_mode         = 1'b1;
              clear_marks();
              rep.entered = 1'b1;
            end else begin
              run_mode        = 1'b0;
              rep.returned    = 1'b1;
              rep.redraw_menu = 1'b1;
            end
          end
        end
        default: ;
      endcase
      rep.mode             = run_mode;
      rep.selection        = menu_index;
      rep.running_function = latched_function;
      pending_reports.push_back(rep);
    endfunction

    function void compare_field(string field, logic [ItemW-1:0] want, logic [ItemW-1:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        errors++;
      end
    endfunction

    // Compares one result beat with the oldest report still owed.
    function void check_report(res_t got);
      res_t want;
      if (pending_reports.size() == 0) begin
        $display("%0t: result beat with none expected, actual mode %0d selection %0d",
                 $time, got.mode, got.selection);
        errors++;
        return;
      end
      want = pending_reports.pop_front();
      compare_field("mode", want.mode, got.mode);
      compare_field("selection", want.selection, got.selection);
      compare_field("running_function", want.running_function, got.running_function);
      compare_field("entered", want.entered, got.entered);
      compare_field("returned", want.returned, got.returned);
      compare_field("redraw_menu", want.redraw_menu, got.redraw_menu);
    endfunction

    function int unsigned pending();
      return pending_reports.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  rms_evt_if evt_if ();
  rms_res_if res_if ();
  rms_cfg_if cfg_if ();

  rotary_menu_selector dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .evt_i  (evt_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  menu_state_tracker menu_tracker;

  int unsigned cycle_count = 0;
  int unsigned burst_left  = 0;
  int unsigned hold_reqs   = 0;
  int unsigned holds_taken = 0;
  int unsigned hold_left   = 0;
  int unsigned stall_left  = 0;
  int unsigned pass_left   = 0;
  bit          turn_ccw    = 1'b0;

  // Clock with a 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("rotary_menu_selector_tb: errors");
      $finish;
    end
  end

  // Result side: short random stalls, long clear stretches, and a long hold-off on request.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      res_if.ready <= 1'b0;
    end else if (hold_reqs != holds_taken) begin
      holds_taken++;
      hold_left = LongHold;
      res_if.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      res_if.ready <= 1'b0;
    end else if (pass_left != 0) begin
      pass_left--;
      res_if.ready <= 1'b1;
    end else begin
      pass_left  = ($urandom_range(3) == 0) ? 40 : $urandom_range(1, 10);
      stall_left = $urandom_range(0, 4);
      res_if.ready <= 1'b1;
    end
  end

  // Beat monitor: checks result beats and feeds accepted event beats to the tracker.
  always @(posedge clk_i) begin : watch
    res_t got;
    evt_t seen;
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        got.mode             = res_if.mode;
        got.selection        = res_if.selection;
        got.running_function = res_if.running_function;
        got.entered          = res_if.entered;
        got.returned         = res_if.returned;
        got.redraw_menu      = res_if.redraw_menu;
        menu_tracker.check_report(got);
      end
      if (evt_if.valid && evt_if.ready) begin
        seen.cmd       = evt_if.cmd;
        seen.a_level   = evt_if.a_level;
        seen.b_level   = evt_if.b_level;
        seen.key_level = evt_if.key_level;
        menu_tracker.note_event(seen);
      end
    end
  end

  // Offers one event beat and returns at the edge that takes it.
  task automatic send_event(input evt_t ev);
    if (burst_left == 0) begin
      int unsigned gap;
      gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        evt_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    evt_if.valid     <= 1'b1;
    evt_if.cmd       <= ev.cmd;
    evt_if.a_level   <= ev.a_level;
    evt_if.b_level   <= ev.b_level;
    evt_if.key_level <= ev.key_level;
    do @(posedge clk_i); while (!evt_if.ready);
  endtask

  // Stops offering events until every report has arrived and the pipeline is empty.
  task automatic wait_drained();
    evt_if.valid <= 1'b0;
    while (menu_tracker.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Writes a list of registers back to back; only called while the block is idle.
  task automatic write_regs(input reg_write_t writes[$]);
    foreach (writes[i]) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= writes[i].idx;
      cfg_if.data  <= writes[i].data;
      do @(posedge clk_i); while (!cfg_if.ready);
      menu_tracker.set_register(writes[i].idx, writes[i].data);
    end
    cfg_if.valid <= 1'b0;
  endtask

  function automatic evt_t tick_event();
    evt_t ev;
    ev           = evt_t'($urandom);
    ev.cmd       = CmdTick;
    return ev;
  endfunction

  // Random event: runs of encoder edges in one direction mixed with ticks, key events and unused commands.
  function automatic evt_t random_event();
    evt_t        ev;
    int unsigned pick;
    ev   = evt_t'($urandom);
    pick = $urandom_range(99);
    if (pick < 40) begin
      if ($urandom_range(4) == 0) turn_ccw = !turn_ccw;
      ev.cmd     = CmdEnc;
      ev.b_level = turn_ccw ? ev.a_level : !ev.a_level;
    end else if (pick < 50) begin
      ev.cmd       = CmdKey;
      ev.key_level = ($urandom_range(3) == 0);
    end else if (pick < 95) begin
      ev.cmd = CmdTick;
    end else begin
      ev.cmd = CmdUnused;
    end
    return ev;
  endfunction

  initial begin : stimulus
    reg_write_t  writes[$];
    logic [10:0] deb;
    logic [3:0]  top;
    menu_tracker = new();
    rst_ni           <= 1'b0;
    evt_if.valid     <= 1'b0;
    evt_if.cmd       <= CmdTick;
    evt_if.a_level   <= 1'b0;
    evt_if.b_level   <= 1'b0;
    evt_if.key_level <= 1'b1;
    cfg_if.valid     <= 1'b0;
    cfg_if.index     <= CfgDebounceTicks;
    cfg_if.data      <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: ignored command, steps both ways, kept start mark, wrap below zero.
    send_event({CmdUnused, 1'b1, 1'b1, 1'b1});
    send_event({CmdEnc, 1'b0, 1'b0, 1'b0});
    send_event({CmdEnc, 1'b1, 1'b1, 1'b1});
    send_event({CmdTick, 1'b0, 1'b0, 1'b1});
    send_event({CmdEnc, 1'b1, 1'b0, 1'b0});
    send_event({CmdEnc, 1'b0, 1'b1, 1'b1});
    send_event({CmdTick, 1'b1, 1'b1, 1'b0});
    send_event({CmdEnc, 1'b1, 1'b0, 1'b1});
    send_event({CmdTick, 1'b0, 1'b1, 1'b1});
    send_event({CmdKey, 1'b1, 1'b1, 1'b1});
    send_event({CmdKey, 1'b0, 1'b0, 1'b0});
    send_event({CmdTick, 1'b0, 1'b0, 1'b0});
    wait_drained();

    // Zero debounce: enter run mode, steps held while running, return and apply them.
    writes = '{'{CfgDebounceTicks, 11'd0}};
    write_regs(writes);
    send_event({CmdKey, 1'b1, 1'b0, 1'b0});
    send_event({CmdTick, 1'b0, 1'b0, 1'b0});
    send_event({CmdEnc, 1'b0, 1'b0, 1'b0});
    send_event({CmdEnc, 1'b1, 1'b1, 1'b0});
    send_event({CmdTick, 1'b1, 1'b1, 1'b1});
    send_event({CmdKey, 1'b0, 1'b1, 1'b0});
    send_event({CmdTick, 1'b0, 1'b0, 1'b0});
    send_event({CmdTick, 1'b0, 1'b0, 1'b0});
    wait_drained();

    // Single-entry menu through a masked write; both directions stay at zero.
    writes = '{'{CfgLastItem, 11'h7F0}, '{CfgDebounceTicks, 11'd1}};
    write_regs(writes);
    send_event({CmdEnc, 1'b1, 1'b1, 1'b0});
    send_event({CmdEnc, 1'b0, 1'b0, 1'b0});
    send_event({CmdTick, 1'b0, 1'b0, 1'b0});
    send_event({CmdEnc, 1'b0, 1'b1, 1'b0});
    send_event({CmdEnc, 1'b1, 1'b0, 1'b0});
    send_event({CmdTick, 1'b0, 1'b0, 1'b0});
    wait_drained();

    // A long threshold counted out tick by tick, with the press taken just past it.
    writes = '{'{CfgDebounceTicks, 11'd150}, '{CfgLastItem, 11'd15}};
    write_regs(writes);
    send_event({CmdKey, 1'b0, 1'b0, 1'b0});
    repeat (153) send_event(tick_event());
    wait_drained();

    // Random phases over several settings, with long result hold-offs in two of them.
    for (int phase = 0; phase < 8; phase++) begin
      deb = (phase < 3) ? 11'(phase) : 11'($urandom_range(0, 6));
      case (phase)
        0: top = 4'd15;
        1: top = 4'd0;
        2: top = 4'd9;
        3: top = 4'd2;
        default: top = 4'($urandom_range(0, 15));
      endcase
      writes = '{'{CfgDebounceTicks, deb}, '{CfgLastItem, {7'($urandom), top}}};
      if (phase == 0) begin
        writes.push_back('{CfgSpareLo, 11'($urandom)});
        writes.push_back('{CfgSpareHi, 11'($urandom)});
      end
      write_regs(writes);
      if (phase == 3 || phase == 6) hold_reqs++;
      repeat (PhaseItems) send_event(random_event());
      wait_drained();
    end

    if (menu_tracker.errors == 0) begin
      $display("rotary_menu_selector_tb: clean");
    end else begin
      $display("rotary_menu_selector_tb: errors");
    end
    $finish;
  end

endmodule
